/* design/bfra_pkg.sv */
// ----------------------------------------------------------------------------
// Best-fit region allocator package
// Shared widths, status codes and the hole cell interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bfra_pkg;

  localparam int HOLE_ENTRIES  = 16;
  localparam int ALLOC_ENTRIES = 16;
  localparam int POS_BITS      = 16;
  localparam int LEN_BITS      = POS_BITS + 1;
  localparam int OWNER_BITS    = 8;
  localparam int HIDX_BITS     = $clog2(HOLE_ENTRIES);
  localparam int AIDX_BITS     = $clog2(ALLOC_ENTRIES);
  localparam int HCNT_BITS     = $clog2(HOLE_ENTRIES + 1);

  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [OWNER_BITS-1:0] owner_t;
  typedef logic [HIDX_BITS-1:0]  hidx_t;
  typedef logic [HCNT_BITS-1:0]  hcnt_t;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_ADD     = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Operation broadcast to every hole cell together.
  typedef enum logic [2:0] {
    HOP_NONE   = 3'd0,
    HOP_SHL    = 3'd1, // cells at or above the index take the right neighbor
    HOP_SHR    = 3'd2, // cells above the index take the left neighbor
    HOP_WRITE  = 3'd3  // the indexed cell takes the given start and length
  } hop_t;

  typedef struct packed {
    hop_t  op;
    hidx_t idx;
    pos_t  start;
    len_t  len;
  } hcmd_t;

  typedef struct packed {
    pos_t start;
    len_t len;
  } hole_t;

endpackage

`default_nettype wire

/* design/bfra_cell.sv */
// ----------------------------------------------------------------------------
// Hole cell
// Holds one hole entry; shifts it to or from its neighbors on command.
// ----------------------------------------------------------------------------
`default_nettype none

module bfra_cell (
  input  wire logic            clk,
  input  wire bfra_pkg::hidx_t my_idx,
  input  wire bfra_pkg::hcmd_t cmd,
  input  wire bfra_pkg::hole_t left_in,
  input  wire bfra_pkg::hole_t right_in,
  output bfra_pkg::hole_t      hole
);
  import bfra_pkg::*;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      HOP_SHL: if (my_idx >= cmd.idx) hole <= right_in;
      HOP_SHR: if (my_idx > cmd.idx) hole <= left_in;
      HOP_WRITE: if (my_idx == cmd.idx) begin
        hole.start <= cmd.start;
        hole.len   <= cmd.len;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/best_fit_region_allocator_top.sv */
// ----------------------------------------------------------------------------
// Best-fit region allocator
// Row of hole cells walked by a sequencer, plus a register allocation table.
// ----------------------------------------------------------------------------
// Each request walks its tables one entry per cycle: allocate scans the holes, add
// scans the holes for its insertion point, release scans the allocation table and
// then the holes; up to two hole updates follow the walk.
// One item in flight; the next beat is taken in the cycle after the result is accepted.
// Synchronous reset empties both tables; no clearing pass is needed.
`default_nettype none

module best_fit_region_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // func[1:0], req_size[18:2], owner_id[26:19], region_start[42:27], zero pad
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0], granted_start[17:2], granted_size[34:18], released_owner[42:35]
  output logic [47:0]      m_tdata
);
  import bfra_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ASCAN  = 7'b0000010,
    S_AUPD   = 7'b0000100,
    S_RSCAN  = 7'b0001000,
    S_ISCAN  = 7'b0010000,
    S_IUPD   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  func_t  func;
  len_t   req;
  owner_t owner;
  pos_t   pos;
  hcnt_t  hole_count;
  hcnt_t  scan;        // walk index over holes
  logic   [AIDX_BITS:0] ascan;
  logic   [AIDX_BITS-1:0] hit;
  hidx_t  pick;
  logic   found_exact, found_any;
  len_t   pick_len;
  hcnt_t  ins_idx;
  logic   ins_done;
  logic   ins_both;
  status_t status;
  pos_t   gstart;
  len_t   gsize;
  owner_t rowner;

  pos_t   a_start [ALLOC_ENTRIES];
  len_t   a_len   [ALLOC_ENTRIES];
  owner_t a_owner [ALLOC_ENTRIES];
  logic   [ALLOC_ENTRIES-1:0] a_valid;

  hcmd_t  cmd;
  hole_t  holes [HOLE_ENTRIES];
  hole_t  cur;

  for (genvar g = 0; g < HOLE_ENTRIES; g++) begin : g_cell
    bfra_cell u_cell (
      .clk      (clk),
      .my_idx   (HIDX_BITS'(g)),
      .cmd      (cmd),
      .left_in  (holes[(g == 0) ? 0 : g-1]),
      .right_in (holes[(g == HOLE_ENTRIES-1) ? g : g+1]),
      .hole     (holes[g])
    );
  end

  assign cur = holes[scan[HIDX_BITS-1:0]];

  // Lowest free allocation slot (priority over 16 valid bits).
  logic [AIDX_BITS-1:0] free_slot;
  logic                 have_free;
  always_comb begin
    free_slot = '0;
    have_free = 1'b0;
    for (int i = ALLOC_ENTRIES-1; i >= 0; i--)
      if (!a_valid[i]) begin
        free_slot = AIDX_BITS'(i);
        have_free = 1'b1;
      end
  end

  // Length and early status of an incoming beat.
  len_t              in_req;
  status_t           in_status;
  logic [LEN_BITS:0] in_end;
  always_comb begin
    in_req = s_tdata[18:2];
    in_end = {1'b0, s_tdata[18:2]} + (LEN_BITS+1)'(s_tdata[42:27]);
    // An added region is clipped at the end of the space.
    if (func_t'(s_tdata[1:0]) == FN_ADD && in_end > ((LEN_BITS+1)'(1) << POS_BITS))
      in_req = len_t'(((LEN_BITS+1)'(1) << POS_BITS) - (LEN_BITS+1)'(s_tdata[42:27]));
    in_status = ST_OK;
    if (func_t'(s_tdata[1:0]) == FN_ALLOC) begin
      if (s_tdata[18:2] == '0) in_status = ST_NOFIT;
      else if (!have_free) in_status = ST_FULL;
    end
  end

  // Merge tests against the holes around the insertion index.
  hole_t lft, rgt;
  logic  mr, ml;
  logic [LEN_BITS:0] endp;
  always_comb begin
    lft = holes[hidx_t'(ins_idx - 1'b1)];
    rgt = holes[ins_idx[HIDX_BITS-1:0]];
    endp = {1'b0, req} + (LEN_BITS+1)'(pos);
    mr = (ins_idx < hole_count) && (endp == (LEN_BITS+1)'(rgt.start));
    ml = (ins_idx != '0) &&
         (({1'b0, lft.len} + (LEN_BITS+1)'(lft.start)) == (LEN_BITS+1)'(pos));
  end

  // Combined merge length for the left hole, taken from the right one too.
  len_t both_len;
  assign both_len = lft.len + req + rgt.len;

  always_comb begin
    cmd = '{op: HOP_NONE, idx: '0, start: '0, len: '0};
    if (state == S_AUPD && found_any) begin
      if (found_exact) cmd = '{op: HOP_SHL, idx: pick, start: '0, len: '0};
      else cmd = '{op: HOP_WRITE, idx: pick, start: holes[pick].start + req[POS_BITS-1:0],
                   len: pick_len - req};
    end else if (state == S_IUPD) begin
      if (!ins_done) begin
        if (mr && ml)  cmd = '{op: HOP_WRITE, idx: hidx_t'(ins_idx - 1'b1),
                               start: lft.start, len: both_len};
        else if (mr)   cmd = '{op: HOP_WRITE, idx: ins_idx[HIDX_BITS-1:0], start: pos,
                               len: rgt.len + req};
        else if (ml)   cmd = '{op: HOP_WRITE, idx: hidx_t'(ins_idx - 1'b1),
                               start: lft.start, len: lft.len + req};
        else if (hole_count != hcnt_t'(HOLE_ENTRIES))
                       cmd = '{op: HOP_SHR, idx: ins_idx[HIDX_BITS-1:0], start: '0, len: '0};
      end else if (ins_both) begin
        // The right hole was folded into the left one; close the gap.
        cmd = '{op: HOP_SHL, idx: ins_idx[HIDX_BITS-1:0], start: '0, len: '0};
      end else begin
        cmd = '{op: HOP_WRITE, idx: ins_idx[HIDX_BITS-1:0], start: pos, len: req};
      end
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {5'd0, rowner, gsize, gstart, status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hole_count <= '0;
      a_valid    <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          func   <= func_t'(s_tdata[1:0]);
          req    <= in_req;
          owner  <= s_tdata[26:19];
          pos    <= s_tdata[42:27];
          status <= in_status;
          gstart <= '0; gsize <= '0; rowner <= '0;
          scan <= '0; ascan <= '0; found_exact <= 1'b0; found_any <= 1'b0;
          ins_done <= 1'b0; ins_both <= 1'b0;
          unique case (func_t'(s_tdata[1:0]))
            FN_ALLOC:   state <= (in_status == ST_OK) ? S_ASCAN : S_OUT;
            FN_RELEASE: state <= S_RSCAN;
            FN_ADD:     state <= S_ISCAN;
            default:    state <= S_OUT;
          endcase
        end
        S_ASCAN: begin
          if (scan == hole_count || found_exact) state <= S_AUPD;
          else begin
            if (cur.len == req) begin
              found_exact <= 1'b1; found_any <= 1'b1;
              pick <= scan[HIDX_BITS-1:0]; pick_len <= cur.len;
            end else if (cur.len > req && (!found_any || cur.len < pick_len)) begin
              found_any <= 1'b1;
              pick <= scan[HIDX_BITS-1:0]; pick_len <= cur.len;
            end
            scan <= scan + 1'b1;
          end
        end
        S_AUPD: begin
          if (!found_any) status <= ST_NOFIT;
          else begin
            gstart <= holes[pick].start;
            gsize  <= req;
            if (found_exact) hole_count <= hole_count - 1'b1;
            a_start[free_slot] <= holes[pick].start;
            a_len[free_slot]   <= req;
            a_owner[free_slot] <= owner;
            a_valid[free_slot] <= 1'b1;
          end
          state <= S_OUT;
        end
        S_RSCAN: begin
          if (ascan == (AIDX_BITS+1)'(ALLOC_ENTRIES)) begin
            status <= ST_NOTFOUND; state <= S_OUT;
          end else if (a_valid[ascan[AIDX_BITS-1:0]] &&
                       a_start[ascan[AIDX_BITS-1:0]] == pos) begin
            hit <= ascan[AIDX_BITS-1:0];
            req <= a_len[ascan[AIDX_BITS-1:0]];
            state <= S_ISCAN;
          end else ascan <= ascan + 1'b1;
        end
        S_ISCAN: begin
          if (func == FN_ADD && req == '0) state <= S_OUT;
          else if (scan == hole_count || cur.start > pos) begin
            ins_idx <= scan;
            state <= S_IUPD;
          end else scan <= scan + 1'b1;
        end
        S_IUPD: begin
          if (!ins_done) begin
            if (mr && ml) begin
              hole_count <= hole_count - 1'b1;
              ins_done <= 1'b1;
              ins_both <= 1'b1;
            end else if (!mr && !ml && hole_count == hcnt_t'(HOLE_ENTRIES)) begin
              status <= ST_FULL; state <= S_OUT;
            end else if (!mr && !ml) begin
              hole_count <= hole_count + 1'b1;
              ins_done <= 1'b1;
            end else state <= S_OUT;
            if (func == FN_RELEASE &&
                !(!mr && !ml && hole_count == hcnt_t'(HOLE_ENTRIES))) begin
              a_valid[hit] <= 1'b0;
              gstart <= pos; gsize <= req; rowner <= a_owner[hit];
            end
          end else state <= S_OUT;
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
